// ===== src/ic3_pkg.sv =====
// shared types and constants of the 3x3 image convolution block
package ic3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = COL_W + 1;
    localparam int PROD_W = 25;
    localparam int PSUM_W = PROD_W + 2;
    localparam int SUM_W = PSUM_W + 2;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COLOR_MODE   = 3'd2;
    localparam logic [2:0] REG_BORDER_VALUE = 3'd3;
    localparam logic [2:0] REG_COEF_TOP     = 3'd4;
    localparam logic [2:0] REG_COEF_MID     = 3'd5;
    localparam logic [2:0] REG_COEF_BOT     = 3'd6;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] chan_red;
        logic [7:0] chan_green;
        logic [7:0] chan_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [2:0] ok_row;
        logic [2:0] ok_col;
        logic       last;
    } meta_t;

endpackage

// ===== src/ic3_cell.sv =====
// one window column cell: holds three pixels and forms the weighted column sums
module ic3_cell
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   shift,
    input  logic [2:0][23:0]                       col_in,
    input  logic [2:0][15:0]                       weights,
    input  logic [2:0]                             ok_row,
    input  logic                                   ok_col,
    input  logic [7:0]                             border,
    output logic [2:0][23:0]                       col_out,
    output logic [2:0][ic3_pkg::PSUM_W-1:0]        psum
);

    logic [2:0][23:0]                col_reg;
    logic [2:0][ic3_pkg::PSUM_W-1:0] psum_reg;
    logic [2:0][ic3_pkg::PSUM_W-1:0] psum_next;

    always_comb
    begin
        logic [7:0]                  v;
        logic [ic3_pkg::PROD_W-1:0]  prod;
        for (int ch = 0; ch < 3; ch++)
        begin
            psum_next[ch] = '0;
            for (int r = 0; r < 3; r++)
            begin
                v = (ok_row[r] && ok_col) ? col_reg[r][8*ch +: 8] : border;
                prod = $signed({{(ic3_pkg::PROD_W - 16){weights[r][15]}}, weights[r]})
                     * $signed({{(ic3_pkg::PROD_W - 8){1'b0}}, v});
                psum_next[ch] = psum_next[ch]
                    + {{(ic3_pkg::PSUM_W - ic3_pkg::PROD_W){prod[ic3_pkg::PROD_W-1]}}, prod};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (en && shift)
        begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

// ===== src/image_convolution_3x3.sv =====
// 3x3 image convolution top level: line stores, position control, cell chain, output register
// Pixels are taken one per clock; a pixel or drain transaction is accepted in every cycle in
// which the output register is empty or its result is being taken. The pipeline is four
// registers deep (line store read, window column cells, column products, sum and rounding);
// the transaction that completes a result trails the pixel it is centred on by one row plus
// one pixel. The line stores are single-port-write memories read one column per transaction
// and need no clearing after reset.
module image_convolution_3x3
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ic3_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ic3_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);

    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        color_mode_reg;
    logic [7:0]  border_value_reg;
    logic [47:0] coef_top_reg, coef_mid_reg, coef_bot_reg;

    logic [ic3_pkg::CNT_W-1:0] in_column_reg, in_column_next;
    logic [16:0]               in_row_reg, in_row_next;
    logic [ic3_pkg::CNT_W-1:0] out_column_reg, out_column_next;
    logic [15:0]               out_row_reg, out_row_next;

    logic [23:0] mem_upper [ic3_pkg::MAX_WIDTH];
    logic [23:0] mem_lower [ic3_pkg::MAX_WIDTH];
    logic [23:0] rd_upper_reg, rd_lower_reg, upper_eff, lower_eff;
    logic        fwd_reg;
    logic [23:0] fwd_upper_reg, fwd_lower_reg;

    logic                      v1_reg, emit1_reg, v2_reg, v3_reg;
    logic [23:0]               px1_reg;
    logic [ic3_pkg::COL_W-1:0] col1_reg;
    ic3_pkg::meta_t            meta1_reg, meta2_reg, meta_next;
    logic                      last3_reg;

    logic               out_valid_reg;
    ic3_pkg::out_item_t out_data_reg;

    logic        en, accept, ignore, proc, emit, clr, last;
    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic [ic3_pkg::CNT_W-1:0] ic, oc, ic_inc, oc_inc;
    logic [16:0] ir;
    logic [15:0] orow;
    logic [23:0] px;
    logic [ic3_pkg::COL_W-1:0] col;

    logic [2:0][2:0][23:0]                  cols;
    logic [2:0][2:0][ic3_pkg::PSUM_W-1:0]   psums;
    logic [2:0][7:0]                        res;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign accept   = in_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd640;
            image_height_reg <= 16'd480;
            color_mode_reg   <= 1'b0;
            border_value_reg <= 8'd125;
            coef_top_reg     <= '0;
            coef_mid_reg     <= 48'h0000_0100_0000;
            coef_bot_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ic3_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                ic3_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[15:0];
                ic3_pkg::REG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                ic3_pkg::REG_BORDER_VALUE: border_value_reg <= cfg_data[7:0];
                ic3_pkg::REG_COEF_TOP:     coef_top_reg     <= cfg_data;
                ic3_pkg::REG_COEF_MID:     coef_mid_reg     <= cfg_data;
                ic3_pkg::REG_COEF_BOT:     coef_bot_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // position control
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = 11'd1;
        else if (image_width_reg > 11'(ic3_pkg::MAX_WIDTH))
            w_eff = 11'(ic3_pkg::MAX_WIDTH);
        else
            w_eff = image_width_reg;
        h_eff = (image_height_reg == '0) ? 16'd1 : image_height_reg;

        clr  = out_row_reg >= h_eff;
        ic   = clr ? '0 : in_column_reg;
        ir   = clr ? '0 : in_row_reg;
        oc   = clr ? '0 : out_column_reg;
        orow = clr ? '0 : out_row_reg;

        ignore = (in_data.opcode == ic3_pkg::OP_DRAIN) && (ir < {1'b0, h_eff});
        proc   = !ignore;
        px     = (ir >= {1'b0, h_eff}) ? 24'd0
               : {in_data.chan_blue, in_data.chan_green, in_data.chan_red};
        emit   = (ir >= 17'd2) || (ir == 17'd1 && ic >= 11'd1);
        col    = ic[ic3_pkg::COL_W-1:0];
        last   = (orow == h_eff - 16'd1) && (oc == w_eff - 11'd1);

        meta_next.ok_row = {(17'({1'b0, orow}) + 17'd1) < {1'b0, h_eff}, 1'b1, orow >= 16'd1};
        meta_next.ok_col = {(oc + 11'd1) < w_eff, 1'b1, oc >= 11'd1};
        meta_next.last   = last;

        ic_inc = ic + 11'd1;
        oc_inc = oc + 11'd1;
        in_column_next  = ic;
        in_row_next     = ir;
        out_column_next = oc;
        out_row_next    = orow;
        if (proc)
        begin
            if (ic_inc >= w_eff)
            begin
                in_column_next = '0;
                in_row_next    = ir + 17'd1;
            end
            else
            begin
                in_column_next = ic_inc;
            end
            if (emit)
            begin
                if (last)
                begin
                    in_column_next  = '0;
                    in_row_next     = '0;
                    out_column_next = '0;
                    out_row_next    = '0;
                end
                else if (oc_inc >= w_eff)
                begin
                    out_column_next = '0;
                    out_row_next    = orow + 16'd1;
                end
                else
                begin
                    out_column_next = oc_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else if (accept)
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

    // line stores, with a bypass when the same column is read straight after its write
    assign upper_eff = fwd_reg ? fwd_upper_reg : rd_upper_reg;
    assign lower_eff = fwd_reg ? fwd_lower_reg : rd_lower_reg;

    always_ff @(posedge clk)
    begin
        if (accept && proc)
        begin
            rd_upper_reg  <= mem_upper[col];
            rd_lower_reg  <= mem_lower[col];
            fwd_upper_reg <= lower_eff;
            fwd_lower_reg <= px1_reg;
        end
        if (en && v1_reg)
        begin
            mem_upper[col1_reg] <= lower_eff;
            mem_lower[col1_reg] <= px1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (accept && proc)
        begin
            fwd_reg <= v1_reg && (col1_reg == col);
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= accept && proc;
            v2_reg        <= v1_reg && emit1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && proc)
        begin
            px1_reg   <= px;
            col1_reg  <= col;
            emit1_reg <= emit;
            meta1_reg <= meta_next;
        end
        if (en)
        begin
            meta2_reg <= meta1_reg;
            last3_reg <= meta2_reg.last;
        end
    end

    // chain of window column cells, newest column at the right
    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_cell
            logic [2:0][23:0] cin;
            if (c == 2)
            begin : g_new
                assign cin = {px1_reg, lower_eff, upper_eff};
            end
            else
            begin : g_shift
                assign cin = cols[c+1];
            end
            ic3_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .shift   (v1_reg),
                .col_in  (cin),
                .weights ({coef_bot_reg[16*c +: 16], coef_mid_reg[16*c +: 16],
                           coef_top_reg[16*c +: 16]}),
                .ok_row  (meta2_reg.ok_row),
                .ok_col  (meta2_reg.ok_col[c]),
                .border  (border_value_reg),
                .col_out (cols[c]),
                .psum    (psums[c])
            );
        end
    endgenerate

    // sum, clamp at zero, round half up and keep bits 15:8 of the rounded sum
    always_comb
    begin
        logic [ic3_pkg::SUM_W-1:0] s;
        logic [ic3_pkg::SUM_W-1:0] r;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = '0;
            for (int k = 0; k < 3; k++)
            begin
                s = s + {{(ic3_pkg::SUM_W - ic3_pkg::PSUM_W){psums[k][ch][ic3_pkg::PSUM_W-1]}},
                         psums[k][ch]};
            end
            r = s + ic3_pkg::SUM_W'(128);
            res[ch] = s[ic3_pkg::SUM_W-1] ? 8'd0 : r[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v3_reg)
        begin
            out_data_reg.out_red    <= res[0];
            out_data_reg.out_green  <= color_mode_reg ? res[1] : 8'd0;
            out_data_reg.out_blue   <= color_mode_reg ? res[2] : 8'd0;
            out_data_reg.last_pixel <= last3_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/ic3_checker.sv =====
// port-level checks of the 3x3 image convolution block and their binding
module ic3_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input ic3_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input ic3_pkg::out_item_t out_data
);

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output register free");

    a_result_leaves_only_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without a transaction");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    a_stalled_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
        else $error("stalled input transaction changed");

endmodule

bind image_convolution_3x3 ic3_checker u_ic3_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
